@@ src/icvu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package icvu_pkg;

  localparam int unsigned SqrtSteps      = 32;
  localparam int unsigned DivSteps       = 32;
  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned CordicMax      = 32;
  localparam int unsigned LatencyCycles  = 9 + SqrtSteps + DivSteps;

  localparam logic signed [33:0] GainInv    = 34'sd652032874;
  localparam logic        [31:0] TurnEighth = 32'h2000_0000;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
  } sqrt_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cord_t;

  typedef struct packed {
    logic               sh;
    logic signed [31:0] c;
    logic signed [49:0] bx;
    logic signed [49:0] by;
    logic signed [49:0] bz;
    logic        [15:0] mp;
    logic        [15:0] mq;
    logic        [16:0] m;
  } side_t;

  typedef struct packed {
    logic [16:0] rem;
    logic [31:0] dq;
    logic        neg;
    logic        sat;
  } div_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      5'd24:   a = 32'h00000029;
      5'd25:   a = 32'h00000014;
      5'd26:   a = 32'h0000000A;
      5'd27:   a = 32'h00000005;
      5'd28:   a = 32'h00000003;
      5'd29:   a = 32'h00000001;
      5'd30:   a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [63:0] bval);
    sqrt_t       o;
    logic [63:0] t;
    t = s.r + bval;
    if (s.v >= t) begin
      o.v = s.v - t;
      o.r = (s.r >> 1) + bval;
    end else begin
      o.v = s.v;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  function automatic cord_t cordic_step(input cord_t a, input logic [4:0] idx);
    cord_t              o;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;
    dx = a.y >>> idx;
    dy = a.x >>> idx;
    at = $signed({2'b00, atan_turn(idx)});
    if (!a.z[33]) begin
      o.x = a.x - dx;
      o.y = a.y + dy;
      o.z = a.z - at;
    end else begin
      o.x = a.x + dx;
      o.y = a.y - dy;
      o.z = a.z + at;
    end
    return o;
  endfunction

  function automatic div_t div_step(input div_t d, input logic [16:0] m);
    div_t        o;
    logic [17:0] t;
    o = d;
    t = {d.rem, d.dq[31]};
    if (t >= {1'b0, m}) begin
      o.rem = 17'(t - {1'b0, m});
      o.dq  = {d.dq[30:0], 1'b1};
    end else begin
      o.rem = t[16:0];
      o.dq  = {d.dq[30:0], 1'b0};
    end
    return o;
  endfunction

endpackage
`default_nettype wire

@@ src/isotropic_collision_velocity_update_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake            Payload
// input     start_i, busy_o      p_vel_{x,y,z}_i, q_vel_{x,y,z}_i, mass_{p,q}_i,
//                                rand_polar_i, rand_azimuth_i
// result    valid_o (strobe)     new_p_vel_{x,y,z}_o, new_q_vel_{x,y,z}_o
//
// One word is taken every cycle; busy_o stays low.
// Each result passes through nine setup and product stages, the 32-stage
// root chain and the 32-stage divider chain on its way to the outputs.
// Reset clears only the valid bits; no result leaves after reset until a word enters.
// The receiver takes every result in the cycle it is shown.
module isotropic_collision_velocity_update_core
  import icvu_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output      logic               busy_o,
  input  wire logic signed [31:0] p_vel_x_i,
  input  wire logic signed [31:0] p_vel_y_i,
  input  wire logic signed [31:0] p_vel_z_i,
  input  wire logic signed [31:0] q_vel_x_i,
  input  wire logic signed [31:0] q_vel_y_i,
  input  wire logic signed [31:0] q_vel_z_i,
  input  wire logic        [15:0] mass_p_i,
  input  wire logic        [15:0] mass_q_i,
  input  wire logic        [15:0] rand_polar_i,
  input  wire logic        [15:0] rand_azimuth_i,
  output      logic               valid_o,
  output      logic signed [31:0] new_p_vel_x_o,
  output      logic signed [31:0] new_p_vel_y_o,
  output      logic signed [31:0] new_p_vel_z_o,
  output      logic signed [31:0] new_q_vel_x_o,
  output      logic signed [31:0] new_q_vel_y_o,
  output      logic signed [31:0] new_q_vel_z_o
);

  logic signed [31:0] pv_in [3];
  logic signed [31:0] qv_in [3];
  logic        [15:0] mp_fix;
  logic        [15:0] mq_fix;

  logic               s1_valid_q;
  logic        [32:0] s1_ad_q  [3];
  logic signed [48:0] s1_mpv_q [3];
  logic signed [48:0] s1_mqv_q [3];
  logic        [15:0] s1_mp_q, s1_mq_q, s1_u_q, s1_w_q;
  logic        [16:0] s1_m_q;

  logic               s2_valid_q;
  logic        [61:0] s2_sq_q   [3];
  logic signed [49:0] s2_base_q [3];
  logic        [30:0] s2_srad_q;
  logic signed [31:0] s2_c_q;
  cord_t              s2_cord_q;
  logic               s2_sh_q;
  logic        [15:0] s2_mp_q, s2_mq_q;
  logic        [16:0] s2_m_q;

  logic               pv_q [0:SqrtSteps];
  sqrt_t              pr_q [0:SqrtSteps];
  sqrt_t              ps_q [0:SqrtSteps];
  cord_t              pc_q [0:SqrtSteps];
  side_t              pd_q [0:SqrtSteps];

  logic               s4_valid_q;
  logic        [33:0] s4_cr_q;
  logic signed [33:0] s4_sc_q, s4_ss_q;
  side_t              s4_side_q;

  logic               s5_valid_q;
  logic signed [34:0] s5_g_q    [3];
  logic signed [49:0] s5_base_q [3];
  logic        [15:0] s5_mp_q, s5_mq_q;
  logic        [16:0] s5_m_q;

  logic               s6_valid_q;
  logic signed [51:0] s6_mqg_q  [3];
  logic signed [51:0] s6_mpg_q  [3];
  logic signed [49:0] s6_base_q [3];
  logic        [16:0] s6_m_q;

  logic               s7_valid_q;
  logic signed [53:0] s7_num_q [6];
  logic        [16:0] s7_m_q;

  logic               dv_q [0:DivSteps];
  div_t               dp_q [0:DivSteps][6];
  logic        [16:0] dm_q [0:DivSteps];

  logic               out_valid_q;
  logic signed [31:0] out_q [6];

  assign busy_o = 1'b0;

  assign pv_in[0] = p_vel_x_i;
  assign pv_in[1] = p_vel_y_i;
  assign pv_in[2] = p_vel_z_i;
  assign qv_in[0] = q_vel_x_i;
  assign qv_in[1] = q_vel_y_i;
  assign qv_in[2] = q_vel_z_i;

  assign mp_fix = (mass_p_i == 16'd0 && mass_q_i == 16'd0) ? 16'd1 : mass_p_i;
  assign mq_fix = (mass_p_i == 16'd0 && mass_q_i == 16'd0) ? 16'd1 : mass_q_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      pv_q[0]     <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      s6_valid_q  <= 1'b0;
      s7_valid_q  <= 1'b0;
      dv_q[0]     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= start_i && !busy_o;
      s2_valid_q  <= s1_valid_q;
      pv_q[0]     <= s2_valid_q;
      s4_valid_q  <= pv_q[SqrtSteps];
      s5_valid_q  <= s4_valid_q;
      s6_valid_q  <= s5_valid_q;
      s7_valid_q  <= s6_valid_q;
      dv_q[0]     <= s7_valid_q;
      out_valid_q <= dv_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      logic signed [32:0] dv;
      dv = 33'(pv_in[k]) - 33'(qv_in[k]);
      s1_ad_q[k]  <= dv[32] ? (~dv + 33'd1) : dv;
      s1_mpv_q[k] <= $signed({1'b0, mp_fix}) * pv_in[k];
      s1_mqv_q[k] <= $signed({1'b0, mq_fix}) * qv_in[k];
    end
    s1_mp_q <= mp_fix;
    s1_mq_q <= mq_fix;
    s1_m_q  <= {1'b0, mp_fix} + {1'b0, mq_fix};
    s1_u_q  <= rand_polar_i;
    s1_w_q  <= rand_azimuth_i;
  end

  always_ff @(posedge clk_i) begin
    logic        sh;
    logic [30:0] h;
    logic [32:0] srad;
    logic [31:0] t;
    sh = s1_ad_q[0][32] | s1_ad_q[0][31] | s1_ad_q[1][32] | s1_ad_q[1][31]
       | s1_ad_q[2][32] | s1_ad_q[2][31];
    for (int k = 0; k < 3; k++) begin
      h = sh ? s1_ad_q[k][31:1] : s1_ad_q[k][30:0];
      s2_sq_q[k]   <= h * h;
      s2_base_q[k] <= 50'(s1_mpv_q[k]) + 50'(s1_mqv_q[k]);
    end
    srad      = {17'd0, s1_u_q} * (33'd65536 - {17'd0, s1_u_q});
    s2_srad_q <= srad[30:0];
    s2_c_q    <= $signed({1'b0, s1_u_q, 15'd0}) - 32'sd1073741824;
    t = {s1_w_q, 16'd0} + TurnEighth;
    s2_cord_q.z <= $signed({4'd0, t[29:0]}) - 34'sd536870912;
    case (t[31:30])
      2'd0: begin
        s2_cord_q.x <= GainInv;
        s2_cord_q.y <= 34'sd0;
      end
      2'd1: begin
        s2_cord_q.x <= 34'sd0;
        s2_cord_q.y <= GainInv;
      end
      2'd2: begin
        s2_cord_q.x <= -GainInv;
        s2_cord_q.y <= 34'sd0;
      end
      default: begin
        s2_cord_q.x <= 34'sd0;
        s2_cord_q.y <= -GainInv;
      end
    endcase
    s2_sh_q <= sh;
    s2_mp_q <= s1_mp_q;
    s2_mq_q <= s1_mq_q;
    s2_m_q  <= s1_m_q;
  end

  always_ff @(posedge clk_i) begin
    pr_q[0].v <= 64'(s2_sq_q[0]) + 64'(s2_sq_q[1]) + 64'(s2_sq_q[2]);
    pr_q[0].r <= 64'd0;
    ps_q[0].v <= 64'({s2_srad_q, 30'd0});
    ps_q[0].r <= 64'd0;
    pc_q[0]   <= s2_cord_q;
    pd_q[0].sh <= s2_sh_q;
    pd_q[0].c  <= s2_c_q;
    pd_q[0].bx <= s2_base_q[0];
    pd_q[0].by <= s2_base_q[1];
    pd_q[0].bz <= s2_base_q[2];
    pd_q[0].mp <= s2_mp_q;
    pd_q[0].mq <= s2_mq_q;
    pd_q[0].m  <= s2_m_q;
  end

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_root
    localparam logic [63:0] RootBit = 64'd1 << (62 - 2 * j);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pv_q[j+1] <= 1'b0;
      end else begin
        pv_q[j+1] <= pv_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      pr_q[j+1] <= sqrt_step(pr_q[j], RootBit);
      ps_q[j+1] <= sqrt_step(ps_q[j], RootBit);
      pd_q[j+1] <= pd_q[j];
    end
    if (j < CORDIC_STEPS && j < CordicMax) begin : g_rot
      always_ff @(posedge clk_i) begin
        pc_q[j+1] <= cordic_step(pc_q[j], 5'(j));
      end
    end else begin : g_pass
      always_ff @(posedge clk_i) begin
        pc_q[j+1] <= pc_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic        [31:0] r;
    logic        [30:0] s;
    logic signed [65:0] p;
    r = pr_q[SqrtSteps].r[31:0];
    s = ps_q[SqrtSteps].r[30:0];
    s4_cr_q <= pd_q[SqrtSteps].sh ? {1'b0, r, 1'b0} : {2'b00, r};
    p = $signed({1'b0, s}) * pc_q[SqrtSteps].x + 66'sd536870912;
    s4_sc_q <= $signed(p[63:30]);
    p = $signed({1'b0, s}) * pc_q[SqrtSteps].y + 66'sd536870912;
    s4_ss_q <= $signed(p[63:30]);
    s4_side_q <= pd_q[SqrtSteps];
  end

  always_ff @(posedge clk_i) begin
    logic signed [68:0] p;
    p = $signed({1'b0, s4_cr_q}) * 69'(s4_side_q.c) + 69'sd536870912;
    s5_g_q[0] <= $signed(p[64:30]);
    p = $signed({1'b0, s4_cr_q}) * s4_sc_q + 69'sd536870912;
    s5_g_q[1] <= $signed(p[64:30]);
    p = $signed({1'b0, s4_cr_q}) * s4_ss_q + 69'sd536870912;
    s5_g_q[2] <= $signed(p[64:30]);
    s5_base_q[0] <= s4_side_q.bx;
    s5_base_q[1] <= s4_side_q.by;
    s5_base_q[2] <= s4_side_q.bz;
    s5_mp_q <= s4_side_q.mp;
    s5_mq_q <= s4_side_q.mq;
    s5_m_q  <= s4_side_q.m;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      s6_mqg_q[k]  <= $signed({1'b0, s5_mq_q}) * s5_g_q[k];
      s6_mpg_q[k]  <= $signed({1'b0, s5_mp_q}) * s5_g_q[k];
      s6_base_q[k] <= s5_base_q[k];
    end
    s6_m_q <= s5_m_q;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      s7_num_q[k]   <= 54'(s6_base_q[k]) + 54'(s6_mqg_q[k]);
      s7_num_q[3+k] <= 54'(s6_base_q[k]) - 54'(s6_mpg_q[k]);
    end
    s7_m_q <= s6_m_q;
  end

  always_ff @(posedge clk_i) begin
    logic [53:0] ab;
    logic [55:0] a;
    for (int ch = 0; ch < 6; ch++) begin
      ab = s7_num_q[ch][53] ? (~s7_num_q[ch] + 54'd1) : s7_num_q[ch];
      a  = 56'(ab) + 56'(s7_m_q[16:1]);
      dp_q[0][ch].neg <= s7_num_q[ch][53];
      dp_q[0][ch].sat <= a >= 56'({s7_m_q, 32'd0});
      dp_q[0][ch].rem <= a[48:32];
      dp_q[0][ch].dq  <= a[31:0];
    end
    dm_q[0] <= s7_m_q;
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else begin
        dv_q[j+1] <= dv_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      for (int ch = 0; ch < 6; ch++) begin
        dp_q[j+1][ch] <= div_step(dp_q[j][ch], dm_q[j]);
      end
      dm_q[j+1] <= dm_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    div_t d;
    for (int ch = 0; ch < 6; ch++) begin
      d = dp_q[DivSteps][ch];
      if (d.neg) begin
        out_q[ch] <= (d.sat || d.dq > 32'h8000_0000) ? 32'sh8000_0000 : $signed(~d.dq + 32'd1);
      end else begin
        out_q[ch] <= (d.sat || d.dq[31]) ? 32'sh7FFF_FFFF : $signed(d.dq);
      end
    end
  end

  assign valid_o       = out_valid_q;
  assign new_p_vel_x_o = out_q[0];
  assign new_p_vel_y_o = out_q[1];
  assign new_p_vel_z_o = out_q[2];
  assign new_q_vel_x_o = out_q[3];
  assign new_q_vel_y_o = out_q[4];
  assign new_q_vel_z_o = out_q[5];

endmodule
`default_nettype wire

@@ src/icvu_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module icvu_checker
  import icvu_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic valid_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o) else $error("busy raised");

  a_word_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LatencyCycles valid_o) else $error("result lost");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##LatencyCycles !valid_o) else $error("result invented");

endmodule

bind isotropic_collision_velocity_update_core icvu_checker u_icvu_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .valid_o (valid_o)
);
`default_nettype wire
